// ===== rtl/dtd_pkg.sv =====
// Shared types and constants of the dictionary token decoder.
package dtd_pkg;

   // Input word: one command with its operands.
   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  in_byte;
      logic [11:0] token_index;
      logic [6:0]  byte_offset;
   } req_word_type;

   // Output word: one beat of decoded bytes.
   typedef struct packed {
      logic [63:0] out_bytes;
      logic [3:0]  out_count;
      logic        last_beat;
   } rsp_word_type;

   // Write request into the dictionary memories.
   typedef struct packed {
      logic        text_we;
      logic        len_we;
      logic [11:0] index;
      logic [6:0]  offset;
      logic [7:0]  data;
   } dict_wr_type;

   // Read request into the dictionary memories.
   typedef struct packed {
      logic        text_re;
      logic        len_re;
      logic [11:0] index;
      logic [6:0]  offset;
   } dict_rd_type;

   // One decoded byte handed to the beat packer.
   typedef struct packed {
      logic       push;
      logic [7:0] data;
      logic       last;
   } pk_push_type;

   // Packer status seen by the controller.
   typedef struct packed {
      logic out_free;
      logic room;
   } pk_status_type;

   // Command codes.
   localparam logic [1:0] CMD_DECODE     = 2'd0;
   localparam logic [1:0] CMD_END        = 2'd1;
   localparam logic [1:0] CMD_WRITE_BYTE = 2'd2;
   localparam logic [1:0] CMD_WRITE_LEN  = 2'd3;

   // Pending decode state.
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_ESCAPE = 2'd1;
   localparam logic [1:0] KIND_PREFIX = 2'd2;

   // Byte classes of the encoded stream.
   localparam logic [7:0] ESCAPE_BYTE = 8'hFF;
   localparam logic [1:0] CLASS_SHORT = 2'b10;
   localparam logic [1:0] CLASS_LONG  = 2'b11;

   // Maximum number of beats one word may cause.
   localparam int MAX_BEATS = 16;

endpackage

// ===== rtl/dictionary_token_decoder.sv =====
// Top level of the dictionary token decoder: command decode, expansion sequencer.
//
//  Port group   Direction  Handshake            Payload
//  req_         in         req_valid/req_stall  req_word (command, byte, index, offset)
//  rsp_         out        rsp_valid/rsp_stall  rsp_word (bytes, count, last beat)
//  csr_         in         csr_wr_en            csr_wr_data (dictionary size)
//
// A literal, escape, prefix, end or write word is handled in the cycle it is accepted.
// A token of n bytes takes a length memory read, then one text memory read
// per byte; the text memory gives one byte a cycle while the packer can take it.
// Reset clears the pending state, dictionary size and sequencer; the dictionary
// memories are not cleared. The input stalls while a token is expanding and
// whenever the output register holds a word that is not taken.
module dictionary_token_decoder #(
   parameter int DICT_ENTRIES = 4096,
   parameter int TOKEN_BYTES  = 128,
   parameter int OUT_LANES    = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dtd_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dtd_pkg::rsp_word_type rsp_word,
   input  logic                  csr_wr_en,
   input  logic [12:0]           csr_wr_data
);
   import dtd_pkg::*;

   localparam int IDX_W = $clog2(DICT_ENTRIES);
   localparam logic [7:0] BYTE_LIMIT = 8'(MAX_BEATS * OUT_LANES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LEN_WAIT,
      ST_EXPAND
   } state_type;

   state_type        state_ff,       state_in;
   logic [1:0]       pend_kind_ff,   pend_kind_in;
   logic [7:0]       pend_prefix_ff, pend_prefix_in;
   logic [12:0]      dict_size_ff;
   logic [IDX_W-1:0] exp_index_ff,   exp_index_in;
   logic [6:0]       total_ff,       total_in;
   logic [6:0]       issued_ff,      issued_in;
   logic [6:0]       left_ff,        left_in;
   logic             have_ff,        have_in;

   dict_wr_type   dict_wr;
   dict_rd_type   dict_rd;
   logic [7:0]    text_rd_data;
   logic [6:0]    len_rd_data;
   pk_push_type   pk_push;
   pk_status_type pk_status;

   logic        accept;
   logic        is_decode;
   logic        lit_push;
   logic [7:0]  lit_byte;
   logic        exp_start;
   logic [11:0] exp_index;
   logic        can_take;
   logic        pushed;
   logic        issue;
   logic [6:0]  clip_len;

   dtd_dict #(
      .DICT_ENTRIES (DICT_ENTRIES),
      .TOKEN_BYTES  (TOKEN_BYTES)
   ) u_dict (
      .clock        (clock),
      .wr           (dict_wr),
      .rd           (dict_rd),
      .text_rd_data (text_rd_data),
      .len_rd_data  (len_rd_data)
   );

   dtd_packer #(
      .OUT_LANES (OUT_LANES)
   ) u_packer (
      .clock     (clock),
      .reset     (reset),
      .push      (pk_push),
      .status    (pk_status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // Word acceptance: only when idle and the output register can take a beat.
   assign req_stall = !(state_ff == ST_IDLE && pk_status.out_free);
   assign accept    = req_valid && !req_stall;
   assign is_decode = req_word.command == CMD_DECODE;

   // Dictionary writes come straight from accepted write words.
   always_comb begin
      dict_wr.text_we = accept && (req_word.command == CMD_WRITE_BYTE);
      dict_wr.len_we  = accept && (req_word.command == CMD_WRITE_LEN);
      dict_wr.index   = req_word.token_index;
      dict_wr.offset  = req_word.byte_offset;
      dict_wr.data    = req_word.in_byte;
   end

   // Classify an encoded byte against the pending state.
   always_comb begin
      lit_push       = 1'b0;
      lit_byte       = req_word.in_byte;
      exp_start      = 1'b0;
      exp_index      = {5'd0, req_word.in_byte[6:0]};
      pend_kind_in   = pend_kind_ff;
      pend_prefix_in = pend_prefix_ff;
      if (accept && req_word.command == CMD_END) begin
         lit_push       = pend_kind_ff != KIND_NONE;
         lit_byte       = (pend_kind_ff == KIND_ESCAPE) ? ESCAPE_BYTE : pend_prefix_ff;
         pend_kind_in   = KIND_NONE;
         pend_prefix_in = '0;
      end else if (accept && is_decode) begin
         priority if (pend_kind_ff == KIND_ESCAPE) begin
            lit_push     = 1'b1;
            pend_kind_in = KIND_NONE;
         end else if (pend_kind_ff == KIND_PREFIX) begin
            exp_start      = 1'b1;
            exp_index      = {pend_prefix_ff[5:0], req_word.in_byte[5:0]};
            pend_kind_in   = KIND_NONE;
            pend_prefix_in = '0;
         end else if (req_word.in_byte == ESCAPE_BYTE) begin
            pend_kind_in = KIND_ESCAPE;
         end else if (req_word.in_byte[7:6] == CLASS_SHORT) begin
            exp_start = 1'b1;
         end else if (req_word.in_byte[7:6] == CLASS_LONG) begin
            pend_kind_in   = KIND_PREFIX;
            pend_prefix_in = req_word.in_byte;
         end else begin
            lit_push = 1'b1;
         end
         // Indices beyond the dictionary expand to nothing.
         if ({1'b0, exp_index} >= dict_size_ff
             || {1'b0, exp_index} >= 13'(DICT_ENTRIES)) begin
            exp_start = 1'b0;
         end
      end
   end

   // Expansion sequencer: length read, then one text read per byte.
   always_comb begin
      state_in     = state_ff;
      exp_index_in = exp_index_ff;
      total_in     = total_ff;
      issued_in    = issued_ff;
      left_in      = left_ff;
      have_in      = have_ff;
      clip_len     = ({1'b0, len_rd_data} > BYTE_LIMIT) ? BYTE_LIMIT[6:0] : len_rd_data;
      can_take     = pk_status.out_free || (pk_status.room && left_ff != 7'd1);
      pushed       = 1'b0;
      issue        = 1'b0;

      dict_rd.len_re  = 1'b0;
      dict_rd.text_re = 1'b0;
      dict_rd.index   = exp_index;
      dict_rd.offset  = '0;

      pk_push.push = 1'b0;
      pk_push.data = lit_byte;
      pk_push.last = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            pk_push.push   = lit_push;
            dict_rd.len_re = exp_start;
            if (exp_start) begin
               exp_index_in = exp_index[IDX_W-1:0];
               state_in     = ST_LEN_WAIT;
            end
         end
         ST_LEN_WAIT: begin
            dict_rd.index = 12'(exp_index_ff);
            if (clip_len == 7'd0) begin
               state_in = ST_IDLE;
            end else begin
               dict_rd.text_re = 1'b1;
               total_in        = clip_len;
               issued_in       = 7'd1;
               left_in         = clip_len;
               have_in         = 1'b1;
               state_in        = ST_EXPAND;
            end
         end
         ST_EXPAND: begin
            dict_rd.index  = 12'(exp_index_ff);
            dict_rd.offset = issued_ff;
            pushed         = have_ff && can_take;
            issue          = (!have_ff || pushed) && (issued_ff != total_ff);
            pk_push.push   = pushed;
            pk_push.data   = text_rd_data;
            pk_push.last   = left_ff == 7'd1;
            dict_rd.text_re = issue;
            issued_in      = issued_ff + 7'(issue);
            left_in        = left_ff - 7'(pushed);
            have_in        = issue || (have_ff && !pushed);
            if (pushed && left_ff == 7'd1) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pend_kind_ff   <= KIND_NONE;
         pend_prefix_ff <= '0;
         dict_size_ff   <= '0;
         total_ff       <= '0;
         issued_ff      <= '0;
         left_ff        <= '0;
         have_ff        <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pend_kind_ff   <= pend_kind_in;
         pend_prefix_ff <= pend_prefix_in;
         total_ff       <= total_in;
         issued_ff      <= issued_in;
         left_ff        <= left_in;
         have_ff        <= have_in;
         if (csr_wr_en) begin
            dict_size_ff <= csr_wr_data;
         end
      end
   end

   // Token index being expanded.
   always_ff @(posedge clock) begin
      exp_index_ff <= exp_index_in;
   end

   // Bytes issued minus the byte held at the memory output equals bytes pushed.
   a_expand_count : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXPAND |-> (total_ff - left_ff) == (issued_ff - 7'(have_ff)))
      else $error("expansion byte counts disagree");

   // The final byte of a token returns the sequencer to idle.
   a_last_to_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXPAND && pk_push.push && pk_push.last) |=> state_ff == ST_IDLE)
      else $error("sequencer did not return to idle after the last byte");

   // A pushed byte in expansion always has a text memory read behind it.
   a_push_has_data : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXPAND && pk_push.push) |-> have_ff && left_ff != 7'd0)
      else $error("byte pushed without text data");

endmodule

// ===== rtl/dtd_dict.sv =====
// Dictionary storage: token text and token length memories, with registered reads.
module dtd_dict #(
   parameter int DICT_ENTRIES = 4096,
   parameter int TOKEN_BYTES  = 128
) (
   input  logic                clock,
   input  dtd_pkg::dict_wr_type wr,
   input  dtd_pkg::dict_rd_type rd,
   output logic [7:0]          text_rd_data,
   output logic [6:0]          len_rd_data
);
   import dtd_pkg::*;

   localparam int IDX_W      = $clog2(DICT_ENTRIES);
   localparam int OFF_W      = $clog2(TOKEN_BYTES);
   localparam int TEXT_DEPTH = DICT_ENTRIES * (2 ** OFF_W);
   localparam int LEN_CAP    = (TOKEN_BYTES < 127) ? TOKEN_BYTES : 127;

   logic [7:0] text_mem [TEXT_DEPTH];
   logic [6:0] len_mem  [DICT_ENTRIES];

   logic [7:0] text_rd_ff;
   logic [6:0] len_rd_ff;

   logic                   index_ok;
   logic                   offset_ok;
   logic [6:0]             len_sat;
   logic [IDX_W+OFF_W-1:0] wr_addr;
   logic [IDX_W+OFF_W-1:0] rd_addr;

   // Range checks and length saturation for writes.
   always_comb begin
      index_ok  = {1'b0, wr.index} < 13'(DICT_ENTRIES);
      offset_ok = {1'b0, wr.offset} < 8'(TOKEN_BYTES);
      len_sat   = (wr.data > 8'(LEN_CAP)) ? 7'(LEN_CAP) : wr.data[6:0];
      wr_addr   = {wr.index[IDX_W-1:0], wr.offset[OFF_W-1:0]};
      rd_addr   = {rd.index[IDX_W-1:0], rd.offset[OFF_W-1:0]};
   end

   // Token text memory: the read register holds when no read is issued.
   always_ff @(posedge clock) begin
      if (wr.text_we && index_ok && offset_ok) begin
         text_mem[wr_addr] <= wr.data;
      end
      if (rd.text_re) begin
         text_rd_ff <= text_mem[rd_addr];
      end
   end

   // Token length memory.
   always_ff @(posedge clock) begin
      if (wr.len_we && index_ok) begin
         len_mem[wr.index[IDX_W-1:0]] <= len_sat;
      end
      if (rd.len_re) begin
         len_rd_ff <= len_mem[rd.index[IDX_W-1:0]];
      end
   end

   assign text_rd_data = text_rd_ff;
   assign len_rd_data  = len_rd_ff;

endmodule

// ===== rtl/dtd_packer.sv =====
// Beat packer: gathers decoded bytes into lanes and holds one output word.
module dtd_packer #(
   parameter int OUT_LANES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dtd_pkg::pk_push_type   push,
   output dtd_pkg::pk_status_type status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dtd_pkg::rsp_word_type  rsp_word
);
   import dtd_pkg::*;

   logic [7:0]   acc_ff [OUT_LANES];
   logic [3:0]   acc_cnt_ff;
   logic         out_valid_ff;
   rsp_word_type out_ff;

   logic         completes;
   logic [63:0]  beat_bytes;

   // A byte completes a beat when it fills the last lane or ends the word.
   always_comb begin
      status.out_free = !out_valid_ff || !rsp_stall;
      status.room     = acc_cnt_ff != 4'(OUT_LANES - 1);
      completes       = push.last || !status.room;
      beat_bytes      = '0;
      for (int l = 0; l < OUT_LANES; l++) begin
         if (4'(l) == acc_cnt_ff) begin
            beat_bytes[8*l +: 8] = push.data;
         end else if (4'(l) < acc_cnt_ff) begin
            beat_bytes[8*l +: 8] = acc_ff[l];
         end
      end
   end

   // Lane accumulator.
   always_ff @(posedge clock) begin
      if (push.push && !completes) begin
         for (int l = 0; l < OUT_LANES; l++) begin
            if (4'(l) == acc_cnt_ff) begin
               acc_ff[l] <= push.data;
            end
         end
      end
   end

   // Fill count and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else if (push.push && completes) begin
         acc_cnt_ff   <= '0;
         out_valid_ff <= 1'b1;
      end else begin
         if (push.push) begin
            acc_cnt_ff <= acc_cnt_ff + 4'd1;
         end
         if (out_valid_ff && !rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Output payload, loaded when a beat is completed.
   always_ff @(posedge clock) begin
      if (push.push && completes) begin
         out_ff.out_bytes <= beat_bytes;
         out_ff.out_count <= acc_cnt_ff + 4'd1;
         out_ff.last_beat <= push.last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

endmodule
